// ===== hdl/rss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants of the route switch sequencer
// Beat payloads, the configuration bundle, command codes and register indexes.
// ----------------------------------------------------------------------------
package rss_pkg;

  // Command codes carried by an input beat.
  localparam logic CMD_SELECT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROUTE_TABLE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SWITCH_COUNT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_SECONDS = 2'd2;

  // Field widths fixed by the interface.
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned ROUTE_W     = 3;
  localparam int unsigned SW_FIELD_W  = 3;
  localparam int unsigned REACHED_W   = 8;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned TIMEOUT_W   = 8;
  localparam int unsigned ELAPSED_W   = 20;
  localparam int unsigned LIMIT_W     = 18;

  // Milliseconds per second and the saturation value of the elapsed counter.
  localparam logic [9:0]           MS_PER_SECOND = 10'd1000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = {ELAPSED_W{1'b1}};

  // Input beat.
  typedef struct packed {
    logic                  command;
    logic [ROUTE_W-1:0]    route_index;
    logic [REACHED_W-1:0]  switch_reached;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic                  busy_res;
    logic                  timed_out;
    logic                  drive_valid;
    logic [SW_FIELD_W-1:0] drive_switch;
    logic                  drive_straight;
    logic [ROUTE_W-1:0]    route_now;
  } out_t;

  // Configuration as seen by the sequencing engine.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] route_table;
    logic [COUNT_W-1:0]    switch_count;
    logic [LIMIT_W-1:0]    timeout_limit_ms;
  } cfg_t;

endpackage

// ===== hdl/rss_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_cfg: configuration registers
// Holds the route table and switch count, and keeps the timeout already
// scaled to milliseconds so the engine only has to compare.
// ----------------------------------------------------------------------------
module rss_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rss_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0]       cfg_data,
  output rss_pkg::cfg_t                        cfg
);

  logic [rss_pkg::CFG_DATA_W-1:0] route_table;
  logic [rss_pkg::COUNT_W-1:0]    switch_count;
  logic [rss_pkg::LIMIT_W-1:0]    timeout_limit;
  logic [rss_pkg::LIMIT_W-1:0]    timeout_limit_next;

  // Seconds times 1000 is a small constant multiply; the top value fits 18 bits.
  assign timeout_limit_next = rss_pkg::LIMIT_W'(cfg_data[rss_pkg::TIMEOUT_W-1:0])
                              * rss_pkg::LIMIT_W'(rss_pkg::MS_PER_SECOND);

  // Register writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      route_table   <= {rss_pkg::CFG_DATA_W{1'b1}};
      switch_count  <= '0;
      timeout_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rss_pkg::REG_ROUTE_TABLE:     route_table   <= cfg_data;
        rss_pkg::REG_SWITCH_COUNT:    switch_count  <= cfg_data[rss_pkg::COUNT_W-1:0];
        rss_pkg::REG_TIMEOUT_SECONDS: timeout_limit <= timeout_limit_next;
        default: ;
      endcase
    end
  end

  assign cfg.route_table      = route_table;
  assign cfg.switch_count     = switch_count;
  assign cfg.timeout_limit_ms = timeout_limit;

endmodule

// ===== hdl/rss_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_engine: route sequencing state and step logic
// Holds route, cursor, elapsed time and the last command of every switch,
// and computes the result of one beat from that state.
// ----------------------------------------------------------------------------
module rss_engine #(
  parameter int unsigned SWITCHES = 8,
  parameter int unsigned ROUTES   = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step_en,
  input  rss_pkg::in_t  in_beat,
  input  rss_pkg::cfg_t cfg,
  output rss_pkg::out_t result
);

  localparam int unsigned CUR_W    = $clog2(SWITCHES + 1);
  localparam int unsigned SW_IDX_W = (SWITCHES > 1) ? $clog2(SWITCHES) : 1;

  logic [rss_pkg::ROUTE_W-1:0]   current_route, current_route_next;
  logic [CUR_W-1:0]              switch_cursor, switch_cursor_next;
  logic [rss_pkg::ELAPSED_W-1:0] elapsed_ms, elapsed_ms_next;
  logic [SWITCHES-1:0]           commanded_known, commanded_known_next;
  logic [SWITCHES-1:0]           commanded_straight, commanded_straight_next;

  logic [CUR_W-1:0]    in_use;
  logic                busy_now;
  logic                busy_after;
  logic [SW_IDX_W-1:0] sw;
  logic                want;
  logic                reached;
  logic                drive;
  logic                late;

  // Switch count above the switches present acts as all of them.
  assign in_use = (cfg.switch_count > rss_pkg::COUNT_W'(SWITCHES))
                  ? CUR_W'(SWITCHES) : CUR_W'(cfg.switch_count);

  assign busy_now = switch_cursor < in_use;
  assign sw       = switch_cursor[SW_IDX_W-1:0];
  assign want     = cfg.route_table[{current_route, rss_pkg::SW_FIELD_W'(sw)}];
  assign reached  = in_beat.switch_reached[rss_pkg::SW_FIELD_W'(sw)];

  // Step: select restarts the route, a tick counts elapsed time and handles the current switch.
  always_comb begin
    current_route_next      = current_route;
    switch_cursor_next      = switch_cursor;
    elapsed_ms_next         = elapsed_ms;
    commanded_known_next    = commanded_known;
    commanded_straight_next = commanded_straight;
    drive                   = 1'b0;
    if (in_beat.command == rss_pkg::CMD_SELECT) begin
      if ({1'b0, in_beat.route_index} >= (rss_pkg::ROUTE_W + 1)'(ROUTES)) begin
        current_route_next = rss_pkg::ROUTE_W'(ROUTES - 1);
      end else begin
        current_route_next = in_beat.route_index;
      end
      switch_cursor_next = '0;
      elapsed_ms_next    = '0;
    end else begin
      if (elapsed_ms != rss_pkg::ELAPSED_MAX) begin
        elapsed_ms_next = elapsed_ms + 1'b1;
      end
      if (busy_now) begin
        if (!commanded_known[sw] || (commanded_straight[sw] != want)) begin
          commanded_known_next[sw]    = 1'b1;
          commanded_straight_next[sw] = want;
          drive                       = 1'b1;
        end else if (reached) begin
          switch_cursor_next = switch_cursor + 1'b1;
        end
      end
    end
  end

  // Status after the update.
  assign busy_after = switch_cursor_next < in_use;
  assign late = busy_after && (cfg.timeout_limit_ms != '0)
                && (elapsed_ms_next > rss_pkg::ELAPSED_W'(cfg.timeout_limit_ms));

  assign result.busy_res       = busy_after;
  assign result.timed_out      = late;
  assign result.drive_valid    = drive;
  assign result.drive_switch   = drive ? rss_pkg::SW_FIELD_W'(sw) : '0;
  assign result.drive_straight = drive & want;
  assign result.route_now      = current_route_next;

  // State registers advance once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_route      <= '0;
      switch_cursor      <= '0;
      elapsed_ms         <= '0;
      commanded_known    <= '0;
      commanded_straight <= '0;
    end else if (step_en) begin
      current_route      <= current_route_next;
      switch_cursor      <= switch_cursor_next;
      elapsed_ms         <= elapsed_ms_next;
      commanded_known    <= commanded_known_next;
      commanded_straight <= commanded_straight_next;
    end
  end

endmodule

// ===== hdl/route_switch_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_switch_sequencer_core: railway route setter
// Usage: write the route table, switch count and timeout through the cfg
// port while the block is idle. Each input beat is either a route select or
// a one millisecond tick carrying the reached bits of all switches; every
// input beat yields exactly one result beat with busy, timeout, an optional
// switch drive command and the current route.
// A beat's result sits in the output register the cycle after acceptance.
// Throughput is one beat per cycle while the receiver keeps up, set by the
// single pass through the step logic between state and output register.
// The input is taken whenever the output register is empty or being drained
// in the same cycle, so a stalled receiver holds the result and stalls the
// input after one beat.
// Reset (synchronous) sets the route table to all straight, switch count
// and timeout to zero, route and cursor to zero, clears elapsed time, marks
// every switch as never commanded and empties the output register.
// ----------------------------------------------------------------------------
module route_switch_sequencer_core #(
  parameter int unsigned SWITCHES = 8,
  parameter int unsigned ROUTES   = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rss_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rss_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [rss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rss_pkg::cfg_t cfg;
  rss_pkg::out_t result;
  logic          step_en;

  // Configuration registers.
  rss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencing state and step logic.
  rss_engine #(
    .SWITCHES (SWITCHES),
    .ROUTES   (ROUTES)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .in_beat (in_data),
    .cfg     (cfg),
    .result  (result)
  );

  // Accept when the output register is free or drains this cycle.
  assign in_ready = !out_valid || out_ready;
  assign step_en  = in_valid && in_ready;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data <= result;
    end
  end

`ifndef SYNTH
  // A drive command is only issued while the route is still being set.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_valid |-> out_data.busy_res)
    else $error("drive beat without busy");

  // A timeout is only reported while busy.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.timed_out |-> out_data.busy_res)
    else $error("timeout beat without busy");

  // Drive fields are zero when no drive is issued.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.drive_valid |->
      (out_data.drive_switch == '0) && !out_data.drive_straight)
    else $error("drive fields set without drive");

  // Every accepted input beat produces a result beat in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");
`endif

endmodule
